@@ sv/serial_command_line_assembler_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the serial command line assembler
// Shared same-cycle-implication and next-cycle-implication property wrappers.
// ----------------------------------------------------------------------------
`ifndef SERIAL_COMMAND_LINE_ASSEMBLER_UNIT_MACROS_SVH
`define SERIAL_COMMAND_LINE_ASSEMBLER_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define SCLA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("scla assertion failed");

// next-cycle implication, disabled during reset
`define SCLA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("scla assertion failed");

`endif

@@ sv/scla_pkg.sv @@
// ----------------------------------------------------------------------------
// Serial command line assembler package
// Sizes, character codes, opcodes, record kinds and register map.
// ----------------------------------------------------------------------------
package scla_pkg;

	// line buffer and slot ring
	localparam int LINE_BYTES = 64;
	localparam int SLOTS      = 2;
	localparam int FILL_W     = $clog2(LINE_BYTES);
	localparam int SLOT_W     = $clog2(SLOTS);

	// payload widths
	localparam int CHAR_W = 8;
	localparam int LEN_W  = 6;
	localparam int CFG_W  = 7;

	// configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	// character codes
	localparam logic [CHAR_W-1:0] CODE_CR = 8'd13;
	localparam logic [CHAR_W-1:0] CODE_BS = 8'd8;

	// input opcodes
	localparam logic OP_CHAR    = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	// record kinds
	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_END  = 1'b1;

	// register indexes (selected by paddr[2])
	localparam logic REG_MIN = 1'b0;
	localparam logic REG_MAX = 1'b1;

	// register reset values
	localparam logic [CFG_W-1:0] MIN_RESET = 7'd32;
	localparam logic [CFG_W-1:0] MAX_RESET = 7'd127;

	// advance a ring slot index with wrap
	function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
		logic [SLOT_W-1:0] n;
		if (s == SLOT_W'(SLOTS - 1)) begin
			n = '0;
		end else begin
			n = s + 1'b1;
		end
		return n;
	endfunction

endpackage

@@ sv/scla_if.sv @@
// ----------------------------------------------------------------------------
// Serial command line assembler channel interfaces
// Valid/ready channels for input commands and output line records.
// ----------------------------------------------------------------------------
interface scla_cmd_if;
	import scla_pkg::*;

	logic              valid;
	logic              ready;
	logic              opcode;
	logic [CHAR_W-1:0] char_in;

	modport source (output valid, output opcode, output char_in, input ready);
	modport sink   (input valid, input opcode, input char_in, output ready);
endinterface

interface scla_rec_if;
	import scla_pkg::*;

	logic              valid;
	logic              ready;
	logic              kind;
	logic [CHAR_W-1:0] data_byte;
	logic [LEN_W-1:0]  line_length;
	logic              last;

	modport source (output valid, output kind, output data_byte, output line_length,
		output last, input ready);
	modport sink   (input valid, input kind, input data_byte, input line_length,
		input last, output ready);
endinterface

@@ sv/scla_ram.sv @@
// ----------------------------------------------------------------------------
// Generic synchronous RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module scla_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port, holds when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ sv/serial_command_line_assembler_unit.sv @@
// ----------------------------------------------------------------------------
// Serial command line assembler
// Builds command lines from received characters and replays finished lines.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one transaction per received character (opcode 0) or per
//   release of the oldest line slot (opcode 1). rec carries the replayed
//   line: one byte record per stored byte, then an end record with the
//   length and last set. min_printable / max_printable sit at byte
//   addresses 0 and 4 of the APB port; they are to be written while idle,
//   which the block does not enforce. A non-return character or a release
//   leaves cmd.ready high. A carriage return holds cmd.ready low while the
//   line is replayed: after the ST_READ state covers the registered RAM
//   read, bytes go out one per cycle while rec does not stall, paced by the
//   line RAM's single read port; an empty line goes straight to ST_END.
//   Results go out through an output register, so the next character is
//   taken while the end record still waits on rec.
//   A stall on rec freezes the replay; nothing is dropped.
//   Reset clears the fill count, both slot pointers, the sequencer and the
//   output register and loads the register defaults (32 and 127). The line
//   RAM needs no clearing: only written entries are ever replayed.
// ----------------------------------------------------------------------------
`include "serial_command_line_assembler_unit_macros.svh"

module serial_command_line_assembler_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	scla_cmd_if.sink                      cmd,
	scla_rec_if.source                    rec,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [scla_pkg::PADDR_W-1:0]  paddr,
	input  logic [scla_pkg::PDATA_W-1:0]  pwdata,
	output logic [scla_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);
	import scla_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_EMIT,
		ST_END
	} state_t;

	state_t              state_q;
	logic [FILL_W-1:0]   fill_q;
	logic [FILL_W-1:0]   len_q;
	logic [FILL_W-1:0]   idx_q;
	logic [SLOT_W-1:0]   wr_slot_q;
	logic [SLOT_W-1:0]   rel_slot_q;
	logic [CFG_W-1:0]    min_q;
	logic [CFG_W-1:0]    max_q;

	logic                out_valid_q;
	logic                out_kind_q;
	logic [CHAR_W-1:0]   out_byte_q;
	logic [LEN_W-1:0]    out_len_q;
	logic                out_last_q;

	logic                cmd_fire;
	logic                out_free;
	logic                ring_full;
	logic                is_print;
	logic                is_cr;
	logic                is_bs;
	logic                char_live;
	logic                ram_we;
	logic                ram_re;
	logic [FILL_W-1:0]   ram_raddr;
	logic [CHAR_W-1:0]   ram_rdata;
	logic                cfg_wr;

	// configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= MIN_RESET;
			max_q <= MAX_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_MIN: min_q <= pwdata[CFG_W-1:0];
				REG_MAX: max_q <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_MIN: prdata = PDATA_W'(min_q);
			REG_MAX: prdata = PDATA_W'(max_q);
			default: prdata = '0;
		endcase
	end

	// character classification
	assign cmd.ready = (state_q == ST_IDLE);
	assign cmd_fire  = cmd.valid && cmd.ready;
	assign ring_full = (next_slot(wr_slot_q) == rel_slot_q);
	assign is_cr     = (cmd.char_in == CODE_CR);
	assign is_bs     = (cmd.char_in == CODE_BS);
	assign is_print  = !cmd.char_in[CHAR_W-1]
		&& (cmd.char_in[CFG_W-1:0] >= min_q) && (cmd.char_in[CFG_W-1:0] <= max_q);
	assign char_live = cmd_fire && (cmd.opcode == OP_CHAR) && !ring_full;

	// output register can take a record this cycle
	assign out_free = !out_valid_q || rec.ready;

	// line store access: append on write port, replay on read port
	assign ram_we    = char_live && !is_cr && !is_bs && is_print;
	assign ram_re    = (state_q == ST_READ)
		|| ((state_q == ST_EMIT) && out_free && (idx_q != len_q - 1'b1));
	assign ram_raddr = (state_q == ST_READ) ? idx_q : idx_q + 1'b1;

	scla_ram #(
		.WIDTH (CHAR_W),
		.DEPTH (LINE_BYTES)
	) u_line_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (fill_q),
		.wdata (cmd.char_in),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// sequencer, line state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			len_q       <= '0;
			idx_q       <= '0;
			wr_slot_q   <= '0;
			rel_slot_q  <= '0;
			out_valid_q <= 1'b0;
			out_kind_q  <= KIND_BYTE;
			out_byte_q  <= '0;
			out_len_q   <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (rec.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_fire && (cmd.opcode == OP_RELEASE)) begin
						if (wr_slot_q != rel_slot_q) begin
							rel_slot_q <= next_slot(rel_slot_q);
						end
					end else if (char_live) begin
						if (is_cr) begin
							len_q     <= fill_q;
							idx_q     <= '0;
							fill_q    <= '0;
							wr_slot_q <= next_slot(wr_slot_q);
							state_q   <= (fill_q == '0) ? ST_END : ST_READ;
						end else if (is_bs) begin
							if (fill_q != '0) begin
								fill_q <= fill_q - 1'b1;
							end
						end else if (is_print) begin
							// a line that reaches the buffer size is dropped
							if (fill_q == FILL_W'(LINE_BYTES - 1)) begin
								fill_q <= '0;
							end else begin
								fill_q <= fill_q + 1'b1;
							end
						end
					end
				end
				ST_READ: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_kind_q  <= KIND_BYTE;
						out_byte_q  <= ram_rdata;
						out_len_q   <= '0;
						out_last_q  <= 1'b0;
						if (idx_q == len_q - 1'b1) begin
							state_q <= ST_END;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				ST_END: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_kind_q  <= KIND_END;
						out_byte_q  <= '0;
						out_len_q   <= LEN_W'(len_q);
						out_last_q  <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rec.valid       = out_valid_q;
	assign rec.kind        = out_kind_q;
	assign rec.data_byte   = out_byte_q;
	assign rec.line_length = out_len_q;
	assign rec.last        = out_last_q;

	// replay index stays inside the finished line
	`SCLA_ASSERT_NOW(a_idx_in_line, clk, arst_n, (state_q == ST_EMIT) || (state_q == ST_READ), idx_q < len_q)

	// a live carriage return takes the next ring slot
	`SCLA_ASSERT_NEXT(a_cr_takes_slot, clk, arst_n, char_live && is_cr, wr_slot_q != $past(wr_slot_q))

	// a release with a pending line frees the oldest slot
	`SCLA_ASSERT_NEXT(a_release_frees, clk, arst_n, cmd_fire && (cmd.opcode == OP_RELEASE) && (wr_slot_q != rel_slot_q), rel_slot_q == $past(next_slot(rel_slot_q)))

	// byte records carry no length and never close the run
	`SCLA_ASSERT_NOW(a_byte_rec_shape, clk, arst_n, out_valid_q && (out_kind_q == KIND_BYTE), !out_last_q && (out_len_q == '0))

endmodule

@@ tb/sv/serial_command_line_assembler_unit_test.sv @@
// ----------------------------------------------------------------------------
// Serial command line assembler testbench
// Sends characters and slot releases, predicts the replayed line records and
// compares every record field by field, with random stalls on both channels.
// ----------------------------------------------------------------------------
module serial_command_line_assembler_unit_test;
	import scla_pkg::*;

	localparam int STUCK_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 10;

	typedef struct packed {
		logic              kind;
		logic [CHAR_W-1:0] data_byte;
		logic [LEN_W-1:0]  line_length;
		logic              last;
	} line_rec_t;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [PDATA_W-1:0]  pwdata;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	scla_cmd_if cmd_ch ();
	scla_rec_if rec_ch ();

	serial_command_line_assembler_unit u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_ch.sink),
		.rec     (rec_ch.source),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// shadow copy of the assembler state
	logic [CHAR_W-1:0] mirror_line [LINE_BYTES];
	int unsigned       mirror_fill;
	logic [SLOT_W-1:0] mirror_wr_slot;
	logic [SLOT_W-1:0] mirror_rel_slot;
	logic [CFG_W-1:0]  mirror_min;
	logic [CFG_W-1:0]  mirror_max;

	line_rec_t replay_q[$];
	int        effective_items;
	int        fail_count;
	bit        steady_line;
	bit        no_idle_final;

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("error %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	function automatic logic [SLOT_W-1:0] slot_after(input logic [SLOT_W-1:0] s);
		return (int'(s) == SLOTS - 1) ? '0 : SLOT_W'(s + 1'b1);
	endfunction

	// line assembly prediction for one accepted transaction
	function automatic void assemble_step(input logic op, input logic [CHAR_W-1:0] ch);
		line_rec_t r;
		int        i;
		if (op == OP_RELEASE) begin
			if (mirror_wr_slot != mirror_rel_slot) begin
				mirror_rel_slot = slot_after(mirror_rel_slot);
				effective_items++;
			end
			return;
		end
		// ring full: character leaves no trace
		if (slot_after(mirror_wr_slot) == mirror_rel_slot) return;
		if (ch == CODE_CR) begin
			for (i = 0; i < int'(mirror_fill); i++) begin
				r = '{KIND_BYTE, mirror_line[i], '0, 1'b0};
				replay_q.push_back(r);
			end
			r = '{KIND_END, '0, LEN_W'(mirror_fill), 1'b1};
			replay_q.push_back(r);
			mirror_fill = 0;
			mirror_wr_slot = slot_after(mirror_wr_slot);
			effective_items++;
		end else if (ch == CODE_BS) begin
			if (mirror_fill > 0) begin
				mirror_fill--;
				effective_items++;
			end
		end else if (ch < 8'd128 && ch >= {1'b0, mirror_min} && ch <= {1'b0, mirror_max}) begin
			if (mirror_fill < LINE_BYTES) mirror_line[mirror_fill] = ch;
			mirror_fill++;
			// overflow discards the line
			if (mirror_fill > LINE_BYTES - 1) mirror_fill = 0;
			effective_items++;
		end
	endfunction

	// sender idle: valid low for a number of cycles, ends on a falling edge
	task automatic idle_sender(input int cycles);
		cmd_ch.valid <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	// pause until every expected record has come back
	task automatic hold_until_drained();
		cmd_ch.valid <= 1'b0;
		wait (replay_q.size() == 0);
		@(negedge clk);
	endtask

	// one command transaction; called and returns on a falling edge
	task automatic send_command(input logic op, input logic [CHAR_W-1:0] ch);
		cmd_ch.valid   <= 1'b1;
		cmd_ch.opcode  <= op;
		cmd_ch.char_in <= ch;
		do @(posedge clk); while (cmd_ch.ready !== 1'b1);
		assemble_step(op, ch);
		@(negedge clk);
		if (!no_idle_final && !steady_line && $urandom_range(0, 99) < 12)
			idle_sender($urandom_range(1, 10));
	endtask

	// register write with readback, only while the block is idle
	task automatic write_register(input logic idx, input logic [CFG_W-1:0] value);
		hold_until_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= PDATA_W'(value);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (idx == REG_MIN) mirror_min = value;
		else mirror_max = value;
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== PDATA_W'(value)) report_mismatch("register readback", prdata,
			PDATA_W'(value));
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic logic [CHAR_W-1:0] pick_line_char();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 80 && mirror_min <= mirror_max)
			return CHAR_W'($urandom_range(mirror_min, mirror_max));
		else if (roll < 90)
			return CODE_BS;
		return CHAR_W'($urandom_range(0, 255));
	endfunction

	// release with nothing pending, backspace on empty line, empty line
	task automatic test_empty_line();
		send_command(OP_RELEASE, 8'hFF);
		send_command(OP_CHAR, CODE_BS);
		send_command(OP_CHAR, CODE_CR);
		send_command(OP_RELEASE, 8'h00);
	endtask

	// character code extremes against the default range
	task automatic test_code_extremes();
		send_command(OP_CHAR, 8'd0);
		send_command(OP_CHAR, 8'd31);
		send_command(OP_CHAR, 8'd32);
		send_command(OP_CHAR, 8'd126);
		send_command(OP_CHAR, 8'd127);
		send_command(OP_CHAR, 8'd128);
		send_command(OP_CHAR, 8'd255);
		send_command(OP_CHAR, CODE_BS);
		send_command(OP_CHAR, CODE_CR);
		send_command(OP_RELEASE, 8'h55);
	endtask

	// every character ignored while the ring is full
	task automatic test_ring_full();
		send_command(OP_CHAR, "A");
		send_command(OP_CHAR, CODE_CR);
		send_command(OP_CHAR, "B");
		send_command(OP_CHAR, CODE_BS);
		send_command(OP_CHAR, CODE_CR);
		hold_until_drained();
		send_command(OP_RELEASE, 8'hAA);
		send_command(OP_RELEASE, 8'h00);
		send_command(OP_CHAR, "C");
		send_command(OP_CHAR, CODE_CR);
		send_command(OP_RELEASE, 8'h00);
	endtask

	// empty, full and single-code printable ranges
	task automatic test_register_range();
		write_register(REG_MIN, 7'd127);
		write_register(REG_MAX, 7'd0);
		send_command(OP_CHAR, "A");
		send_command(OP_CHAR, CODE_CR);
		send_command(OP_RELEASE, 8'h00);
		write_register(REG_MIN, 7'd0);
		write_register(REG_MAX, 7'd127);
		send_command(OP_CHAR, 8'd0);
		send_command(OP_CHAR, 8'd127);
		send_command(OP_CHAR, 8'd9);
		send_command(OP_CHAR, CODE_CR);
		send_command(OP_RELEASE, 8'h00);
		write_register(REG_MIN, 7'd65);
		write_register(REG_MAX, 7'd65);
		send_command(OP_CHAR, "A");
		send_command(OP_CHAR, "B");
		send_command(OP_CHAR, CODE_CR);
		send_command(OP_RELEASE, 8'h00);
	endtask

	// random lines, some long enough to overflow, with noise in between
	task automatic test_random_lines(input int budget);
		int start;
		int len;
		int k;
		start = effective_items;
		while (effective_items - start < budget) begin
			steady_line = ($urandom_range(0, 99) < 30);
			len = ($urandom_range(0, 99) < 15) ? $urandom_range(55, 70) : $urandom_range(0, 20);
			for (k = 0; k < len; k++) begin
				if ($urandom_range(0, 99) < 4)
					send_command(OP_RELEASE, CHAR_W'($urandom_range(0, 255)));
				else
					send_command(OP_CHAR, pick_line_char());
			end
			send_command(OP_CHAR, CODE_CR);
			if ($urandom_range(0, 99) < 30)
				repeat ($urandom_range(1, 4))
					send_command(OP_CHAR, CHAR_W'($urandom_range(0, 255)));
			if (!no_idle_final && $urandom_range(0, 99) < 10) hold_until_drained();
			send_command(OP_RELEASE, CHAR_W'($urandom_range(0, 255)));
		end
		steady_line = 1'b0;
	endtask

	// record sink ready with random stall bursts
	initial begin
		int stall_left;
		stall_left = 0;
		rec_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_left > 0 && !no_idle_final) begin
				rec_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				rec_ch.ready <= 1'b1;
				if (!no_idle_final && !steady_line && $urandom_range(0, 99) < 10)
					stall_left = $urandom_range(1, 10);
			end
		end
	end

	// compare each record transaction with the oldest expectation
	always @(posedge clk) begin
		line_rec_t want;
		if (arst_n && rec_ch.valid === 1'b1 && rec_ch.ready === 1'b1) begin
			if (replay_q.size() == 0) begin
				report_mismatch("unexpected record kind", rec_ch.kind, 0);
			end else begin
				want = replay_q.pop_front();
				if (rec_ch.kind !== want.kind)
					report_mismatch("kind", rec_ch.kind, want.kind);
				if (rec_ch.data_byte !== want.data_byte)
					report_mismatch("data_byte", rec_ch.data_byte, want.data_byte);
				if (rec_ch.line_length !== want.line_length)
					report_mismatch("line_length", rec_ch.line_length, want.line_length);
				if (rec_ch.last !== want.last)
					report_mismatch("last", rec_ch.last, want.last);
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		int stuck;
		if (!arst_n) begin
			stuck = 0;
		end else if ((cmd_ch.valid && cmd_ch.ready) || (rec_ch.valid && rec_ch.ready) || psel) begin
			stuck = 0;
		end else begin
			stuck++;
			if (stuck >= STUCK_LIMIT) begin
				$display("serial_command_line_assembler_unit: mismatch");
				$finish;
			end
		end
	end

	// main sequence
	initial begin
		arst_n          = 1'b0;
		cmd_ch.valid    = 1'b0;
		cmd_ch.opcode   = OP_CHAR;
		cmd_ch.char_in  = '0;
		psel            = 1'b0;
		penable         = 1'b0;
		pwrite          = 1'b0;
		paddr           = '0;
		pwdata          = '0;
		mirror_fill     = 0;
		mirror_wr_slot  = '0;
		mirror_rel_slot = '0;
		mirror_min      = MIN_RESET;
		mirror_max      = MAX_RESET;
		effective_items = 0;
		fail_count      = 0;
		steady_line     = 1'b0;
		no_idle_final   = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_empty_line();
		test_code_extremes();
		test_ring_full();
		test_register_range();

		write_register(REG_MIN, MIN_RESET);
		write_register(REG_MAX, MAX_RESET);
		test_random_lines(60);
		write_register(REG_MIN, CFG_W'($urandom_range(0, 63)));
		write_register(REG_MAX, CFG_W'($urandom_range(64, 127)));
		test_random_lines(45);
		write_register(REG_MIN, 7'd0);
		write_register(REG_MAX, 7'd127);
		test_random_lines(40);
		write_register(REG_MIN, 7'd33);
		write_register(REG_MAX, 7'd126);
		no_idle_final = 1'b1;
		test_random_lines(35);

		// drain and settle
		cmd_ch.valid <= 1'b0;
		wait (replay_q.size() == 0);
		repeat (20) @(posedge clk);
		if (replay_q.size() != 0)
			report_mismatch("records never delivered", 0, replay_q.size());
		if (fail_count == 0)
			$display("serial_command_line_assembler_unit: match");
		else
			$display("serial_command_line_assembler_unit: mismatch");
		$finish;
	end

endmodule
